// File: rtl/core/battery_soc_kalman_estimator_assert.svh
// Assertion macros used by the estimator datapath.
`ifndef BATTERY_SOC_KALMAN_ESTIMATOR_ASSERT_SVH
`define BATTERY_SOC_KALMAN_ESTIMATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSKF_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("bskf: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BSKF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("bskf: next-cycle check failed");

`endif

// File: rtl/core/bskf_pkg.sv
// Package with types, constants and codes of the battery charge estimator.
package bskf_pkg;

	localparam int FRAC_BITS_DEF = 16;

	localparam int CUR_W      = 20;
	localparam int VOLT_W     = 16;
	localparam int SOC_W      = 18;
	localparam int GAIN_W     = 17;
	localparam int COV_W      = 24;
	localparam int ISOC_W     = 17;
	localparam int STEP_W     = 16;
	localparam int CAP_W      = 20;
	localparam int MV_W       = 16;
	localparam int PROD_W     = 36;
	localparam int DEN_W      = 42;
	localparam int PPRED_W    = 25;
	localparam int SUM_W      = 26;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 24;

	localparam logic [DEN_W-1:0] MS_PER_HOUR = DEN_W'(3600000);

	localparam logic [COV_W-1:0]  PN_RESET    = COV_W'(655);
	localparam logic [COV_W-1:0]  MN_RESET    = COV_W'(6554);
	localparam logic [ISOC_W-1:0] ISOC_RESET  = ISOC_W'(32768);
	localparam logic [COV_W-1:0]  ICOV_RESET  = COV_W'(6554);
	localparam logic [STEP_W-1:0] STEP_RESET  = STEP_W'(100);
	localparam logic [CAP_W-1:0]  CAP_RESET   = CAP_W'(10000);
	localparam logic [MV_W-1:0]   EMPTY_RESET = MV_W'(3600);
	localparam logic [MV_W-1:0]   FULL_RESET  = MV_W'(4200);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PROCESS_NOISE      = 4'd0,
		CFG_MEASUREMENT_NOISE  = 4'd1,
		CFG_INITIAL_SOC        = 4'd2,
		CFG_INITIAL_COVARIANCE = 4'd3,
		CFG_STEP_TIME_MS       = 4'd4,
		CFG_CAPACITY_MAH       = 4'd5,
		CFG_EMPTY_MV           = 4'd6,
		CFG_FULL_MV            = 4'd7
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_PROD, ST_DDIV, ST_DWAIT, ST_PRED, ST_MDIV, ST_MWAIT,
		ST_GDIV, ST_GWAIT, ST_SMUL, ST_SWAIT, ST_PMUL, ST_PWAIT, ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		DIV_DELTA, DIV_MEAS, DIV_GAIN
	} div_sel_t;

	typedef enum logic {
		MUL_SOC, MUL_COV
	} mul_sel_t;

	typedef struct packed {
		logic signed [CUR_W-1:0] current_ma;
		logic [VOLT_W-1:0]       voltage_mv;
	} in_t;

	typedef struct packed {
		logic signed [SOC_W-1:0] soc_estimate;
		logic [GAIN_W-1:0]       kalman_gain;
		logic [COV_W-1:0]        error_covariance;
	} out_t;

	typedef struct packed {
		logic     load;
		logic     prod;
		logic     div_start;
		div_sel_t div_sel;
		logic     take_delta;
		logic     pred;
		logic     take_meas;
		logic     take_gain;
		logic     mul_start;
		mul_sel_t mul_sel;
		logic     take_soc;
		logic     emit;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic mul_busy;
		logic meas_direct;
		logic sum_zero;
		logic out_full;
	} stat_t;

endpackage

// File: rtl/core/bskf_div.sv
// Restoring divider that produces one quotient bit per cycle.
module bskf_div
	import bskf_pkg::*;
#(
	parameter int NUM_W = PROD_W + FRAC_BITS_DEF,
	parameter int DIV_W = DEN_W,
	parameter int CNT_W = $clog2(NUM_W + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DIV_W-1:0] den,
	input  logic [CNT_W-1:0] count,
	output logic             busy,
	output logic [NUM_W-1:0] quo
);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   trial_sub;
	logic             ge;

	always_comb begin
		trial     = {rem_q, quo_q[NUM_W-1]};
		trial_sub = trial - {1'b0, den_q};
		ge        = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= (count != '0);
			cnt_q  <= count;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

// File: rtl/core/bskf_dp.sv
// Datapath of the estimator: registers, state, shared divider and serial multiplier.
`include "battery_soc_kalman_estimator_assert.svh"

module bskf_dp
	import bskf_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output stat_t                 stat,
	input  in_t                   in_data,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_t                  out_data
);

	localparam int DIVN     = PROD_W + FRAC_BITS;
	localparam int DCNT_W   = $clog2(DIVN + 1);
	localparam int MNUM_W   = MV_W + 1 + FRAC_BITS;
	localparam int GNUM_W   = SUM_W + FRAC_BITS;
	localparam int MEAS_PAD = DIVN - MNUM_W;
	localparam int GAIN_PAD = DIVN - GNUM_W;
	localparam int SPW      = DIVN + 2;
	localparam int DFW      = SPW + 1;
	localparam int PW       = DFW + FRAC_BITS + 1;
	localparam int RW       = PW - FRAC_BITS;
	localparam int SOCF     = SPW + 3;
	localparam int MCNT_W   = $clog2(FRAC_BITS + 2);

	localparam logic [FRAC_BITS:0] ONE_Q  = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [PW-1:0]      HALF_Q = PW'(1) << (FRAC_BITS - 1);
	localparam logic signed [SOCF-1:0] SOC_MAX_X = SOCF'(131071);
	localparam logic signed [SOCF-1:0] SOC_MIN_X = SOCF'(-131072);
	localparam logic signed [SOC_W-1:0] SOC_MAX_V = SOC_W'(131071);
	localparam logic signed [SOC_W-1:0] SOC_MIN_V = SOC_W'(-131072);

	// Configuration registers and filter state.
	logic [COV_W-1:0]  pn_q, mn_q;
	logic [STEP_W-1:0] step_q;
	logic [CAP_W-1:0]  cap_q;
	logic [MV_W-1:0]   emv_q, fmv_q;
	logic signed [SOC_W-1:0] soc_state_q;
	logic [COV_W-1:0]  cov_state_q;

	// Per-item working registers.
	logic              neg_q;
	logic [CUR_W-1:0]  cmag_q;
	logic [VOLT_W-1:0] volt_q;
	logic [PROD_W-1:0] prod1_q;
	logic [DEN_W-1:0]  den_q;
	logic [PPRED_W-1:0] ppred_q;
	logic [SUM_W-1:0]  sum_q;
	logic signed [SPW-1:0] socp_q;
	logic [FRAC_BITS:0] meas_q;
	logic [FRAC_BITS:0] gain_q;
	logic              meas_direct_q;
	logic              sum_zero_q;
	logic              dneg_q;
	logic signed [SOC_W-1:0] socn_q;
	logic              out_valid_q;
	out_t              out_q;

	// Serial multiplier.
	logic              mul_busy_q;
	logic [MCNT_W-1:0] mcnt_q;
	logic [FRAC_BITS:0] ma_q;
	logic [PW-1:0]     mb_q;
	logic [PW-1:0]     acc_q;

	// Divider port.
	logic              div_busy;
	logic [DIVN-1:0]   div_quo;
	logic [DIVN-1:0]   div_num;
	logic [DEN_W-1:0]  div_den;
	logic [DCNT_W-1:0] div_cnt;

	logic [CUR_W-1:0]  cur_raw;
	logic [CAP_W-1:0]  cap_eff;
	logic [MV_W-1:0]   span;
	logic [MV_W-1:0]   vdiff;
	logic [MNUM_W-1:0] mnum;
	logic [GNUM_W-1:0] gnum;
	logic signed [DFW-1:0] diff;
	logic [DFW-1:0]    diff_mag;
	logic [RW-1:0]     rnd;
	logic signed [SOCF-1:0] soc_full;
	logic [COV_W-1:0]  cov_new;
	logic              out_full;

	always_comb begin
		cur_raw  = in_data.current_ma;
		cap_eff  = (cap_q == '0) ? CAP_W'(1) : cap_q;
		span     = fmv_q - emv_q;
		vdiff    = volt_q - emv_q;
		mnum     = {1'b0, vdiff, {FRAC_BITS{1'b0}}} + MNUM_W'(span >> 1);
		gnum     = {1'b0, ppred_q, {FRAC_BITS{1'b0}}} + GNUM_W'(sum_q >> 1);
		diff     = $signed(DFW'({1'b0, meas_q})) - $signed({socp_q[SPW-1], socp_q});
		diff_mag = diff[DFW-1] ? DFW'(-diff) : DFW'(diff);
		rnd      = RW'((acc_q + HALF_Q) >> FRAC_BITS);
		if (dneg_q) begin
			soc_full = $signed({{3{socp_q[SPW-1]}}, socp_q}) - $signed(SOCF'({1'b0, rnd}));
		end else begin
			soc_full = $signed({{3{socp_q[SPW-1]}}, socp_q}) + $signed(SOCF'({1'b0, rnd}));
		end
		cov_new  = (|rnd[RW-1:COV_W]) ? {COV_W{1'b1}} : rnd[COV_W-1:0];
		out_full = out_valid_q && out_stall;
	end

	always_comb begin
		unique case (cmd.div_sel)
			DIV_DELTA: begin
				div_num = {prod1_q, {FRAC_BITS{1'b0}}} + DIVN'(den_q >> 1);
				div_den = den_q;
				div_cnt = DCNT_W'(DIVN);
			end
			DIV_MEAS: begin
				div_num = {mnum, {MEAS_PAD{1'b0}}};
				div_den = DEN_W'(span);
				div_cnt = DCNT_W'(MNUM_W);
			end
			DIV_GAIN: begin
				div_num = {gnum, {GAIN_PAD{1'b0}}};
				div_den = DEN_W'(sum_q);
				div_cnt = DCNT_W'(GNUM_W);
			end
			default: begin
				div_num = '0;
				div_den = '0;
				div_cnt = '0;
			end
		endcase
	end

	bskf_div #(
		.NUM_W (DIVN),
		.DIV_W (DEN_W),
		.CNT_W (DCNT_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.count  (div_cnt),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	// Configuration, filter state and output handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pn_q        <= PN_RESET;
			mn_q        <= MN_RESET;
			step_q      <= STEP_RESET;
			cap_q       <= CAP_RESET;
			emv_q       <= EMPTY_RESET;
			fmv_q       <= FULL_RESET;
			soc_state_q <= SOC_W'(ISOC_RESET);
			cov_state_q <= ICOV_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				soc_state_q <= socn_q;
				cov_state_q <= cov_new;
			end
			if (cfg_valid) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_PROCESS_NOISE:      pn_q <= cfg_data[COV_W-1:0];
					CFG_MEASUREMENT_NOISE:  mn_q <= cfg_data[COV_W-1:0];
					CFG_INITIAL_SOC:        soc_state_q <= SOC_W'(cfg_data[ISOC_W-1:0]);
					CFG_INITIAL_COVARIANCE: cov_state_q <= cfg_data[COV_W-1:0];
					CFG_STEP_TIME_MS:       step_q <= cfg_data[STEP_W-1:0];
					CFG_CAPACITY_MAH:       cap_q  <= cfg_data[CAP_W-1:0];
					CFG_EMPTY_MV:           emv_q  <= cfg_data[MV_W-1:0];
					CFG_FULL_MV:            fmv_q  <= cfg_data[MV_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// Working registers of one item.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q  <= cur_raw[CUR_W-1];
			cmag_q <= cur_raw[CUR_W-1] ? (CUR_W'(0) - cur_raw) : cur_raw;
			volt_q <= in_data.voltage_mv;
		end
		if (cmd.prod) begin
			prod1_q <= PROD_W'(cmag_q) * PROD_W'(step_q);
			den_q   <= DEN_W'(cap_eff) * MS_PER_HOUR;
			ppred_q <= PPRED_W'(cov_state_q) + PPRED_W'(pn_q);
		end
		if (cmd.take_delta) begin
			if (neg_q) begin
				socp_q <= SPW'(soc_state_q) + $signed(SPW'(div_quo));
			end else begin
				socp_q <= SPW'(soc_state_q) - $signed(SPW'(div_quo));
			end
		end
		if (cmd.pred) begin
			sum_q      <= SUM_W'(ppred_q) + SUM_W'(mn_q);
			sum_zero_q <= (ppred_q == '0) && (mn_q == '0);
			gain_q     <= '0;
			if (fmv_q <= emv_q) begin
				meas_direct_q <= 1'b1;
				meas_q        <= (volt_q > emv_q) ? ONE_Q : '0;
			end else if (volt_q <= emv_q) begin
				meas_direct_q <= 1'b1;
				meas_q        <= '0;
			end else if (volt_q >= fmv_q) begin
				meas_direct_q <= 1'b1;
				meas_q        <= ONE_Q;
			end else begin
				meas_direct_q <= 1'b0;
			end
		end
		if (cmd.take_meas) begin
			meas_q <= div_quo[FRAC_BITS:0];
		end
		if (cmd.take_gain) begin
			gain_q <= div_quo[FRAC_BITS:0];
		end
		if (cmd.take_soc) begin
			if (soc_full > SOC_MAX_X) begin
				socn_q <= SOC_MAX_V;
			end else if (soc_full < SOC_MIN_X) begin
				socn_q <= SOC_MIN_V;
			end else begin
				socn_q <= soc_full[SOC_W-1:0];
			end
		end
		if (cmd.emit) begin
			out_q.soc_estimate     <= socn_q;
			out_q.kalman_gain      <= GAIN_W'(gain_q);
			out_q.error_covariance <= cov_new;
		end
	end

	// Shift-and-add multiplier, one multiplier bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_busy_q <= 1'b0;
			mcnt_q     <= '0;
		end else if (cmd.mul_start) begin
			mul_busy_q <= 1'b1;
			mcnt_q     <= MCNT_W'(FRAC_BITS + 1);
		end else if (mul_busy_q) begin
			mcnt_q <= mcnt_q - MCNT_W'(1);
			if (mcnt_q == MCNT_W'(1)) begin
				mul_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			acc_q <= '0;
			if (cmd.mul_sel == MUL_SOC) begin
				ma_q   <= gain_q;
				mb_q   <= PW'(diff_mag);
				dneg_q <= diff[DFW-1];
			end else begin
				ma_q <= ONE_Q - gain_q;
				mb_q <= PW'(ppred_q);
			end
		end else if (mul_busy_q) begin
			if (ma_q[0]) begin
				acc_q <= acc_q + mb_q;
			end
			ma_q <= ma_q >> 1;
			mb_q <= mb_q << 1;
		end
	end

	always_comb begin
		stat.div_busy    = div_busy;
		stat.mul_busy    = mul_busy_q;
		stat.meas_direct = meas_direct_q;
		stat.sum_zero    = sum_zero_q;
		stat.out_full    = out_full;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`BSKF_ASSERT_HOLDS(a_div_start_idle, clk, arst_n, cmd.div_start, !div_busy)
	`BSKF_ASSERT_HOLDS(a_mul_start_idle, clk, arst_n, cmd.mul_start, !(mul_busy_q || div_busy))
	`BSKF_ASSERT_NEXT(a_gain_in_range, clk, arst_n, cmd.take_gain, gain_q <= ONE_Q)
	`BSKF_ASSERT_HOLDS(a_emit_room, clk, arst_n, cmd.emit, !out_full)

endmodule

// File: rtl/core/bskf_ctrl.sv
// Controller state machine that sequences one estimator update.
module bskf_ctrl
	import bskf_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.div_sel = DIV_DELTA;
		cmd.mul_sel = MUL_SOC;
		in_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_PROD;
				end
			end
			ST_PROD: begin
				cmd.prod = 1'b1;
				state_d  = ST_DDIV;
			end
			ST_DDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_DELTA;
				state_d       = ST_DWAIT;
			end
			ST_DWAIT: begin
				if (!stat.div_busy) begin
					cmd.take_delta = 1'b1;
					state_d        = ST_PRED;
				end
			end
			ST_PRED: begin
				cmd.pred = 1'b1;
				state_d  = ST_MDIV;
			end
			ST_MDIV: begin
				cmd.div_sel = DIV_MEAS;
				if (stat.meas_direct) begin
					state_d = ST_GDIV;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_MWAIT;
				end
			end
			ST_MWAIT: begin
				if (!stat.div_busy) begin
					cmd.take_meas = 1'b1;
					state_d       = ST_GDIV;
				end
			end
			ST_GDIV: begin
				cmd.div_sel = DIV_GAIN;
				if (stat.sum_zero) begin
					state_d = ST_SMUL;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_GWAIT;
				end
			end
			ST_GWAIT: begin
				if (!stat.div_busy) begin
					cmd.take_gain = 1'b1;
					state_d       = ST_SMUL;
				end
			end
			ST_SMUL: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = MUL_SOC;
				state_d       = ST_SWAIT;
			end
			ST_SWAIT: begin
				if (!stat.mul_busy) begin
					cmd.take_soc = 1'b1;
					state_d      = ST_PMUL;
				end
			end
			ST_PMUL: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = MUL_COV;
				state_d       = ST_PWAIT;
			end
			ST_PWAIT: begin
				if (!stat.mul_busy) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!stat.out_full) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/core/battery_soc_kalman_estimator.sv
// Top level of the scalar Kalman battery state-of-charge estimator.
//
// Each input transaction carries one current sample (mA, positive is discharge)
// and one voltage sample (mV). The block predicts the charge by coulomb counting,
// maps the voltage onto a measured charge, blends the two with the Kalman gain
// and returns one result transaction with the estimate, the gain and the updated
// error covariance. Input and output both use valid and stall; a transaction
// moves on a clock edge with valid high and stall low.
// The configuration channel takes one register write per cycle (ready is always
// high); the user must write it only while no update is in flight, which the
// block itself does not enforce. The charge, measurement and gain divisions run in
// turn on the one-bit-per-cycle divider, followed by two serial multiplies.
// The measurement division is skipped when the voltage is out of range or the
// thresholds are not ordered, and the gain division when its denominator is zero.
// No new input is taken while an update is in flight; the next item is accepted
// once the result has been written.
// A stalled result is held in the output register; a finished update waits for
// it to drain before its own result is written.
// Reset loads the register defaults and sets the estimate and covariance to the
// initial charge and covariance; writing those two registers reloads the state.
module battery_soc_kalman_estimator
	import bskf_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_t                   in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_t                  out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t  cmd;
	stat_t stat;

	// Configuration registers accept a write in any cycle.
	assign cfg_ready = 1'b1;

	bskf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	bskf_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (in_data),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
